[src/delimited_decimal_list_parser_macros.svh]
// assertion macros used by the decimal list parser core
`ifndef DELIMITED_DECIMAL_LIST_PARSER_MACROS_SVH
`define DELIMITED_DECIMAL_LIST_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on the block clock outside reset
`define DDLP_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ddlp assertion failed");

// next-cycle implication, checked on the block clock outside reset
`define DDLP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ddlp assertion failed");

`else

`define DDLP_ASSERT_IMPL(label, ante, cons)
`define DDLP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[src/ddlp_pkg.sv]
// types, character codes and helpers for the decimal list parser
package ddlp_pkg;

   localparam int DATA_W     = 32;
   localparam int CHAR_W     = 8;
   localparam int OUT_FIELDS = 6;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_SEMI  = 8'h3B;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   localparam logic [CSR_ADDR_W-1:0] REG_ABSENT_VALUE = '0;
   localparam logic [DATA_W-1:0]     ABSENT_RESET     = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      KIND_OTHER,
      KIND_DIGIT,
      KIND_SEP,
      KIND_MINUS
   } char_kind_type;

   typedef struct packed {
      logic [OUT_FIELDS-1:0]             present_mask;
      logic [OUT_FIELDS-1:0][DATA_W-1:0] fields;
   } result_type;

   function automatic char_kind_type classify(input logic [CHAR_W-1:0] c);
      char_kind_type kind;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         kind = KIND_DIGIT;
      end else if (c == CHAR_SEMI || c == CHAR_COLON) begin
         kind = KIND_SEP;
      end else if (c == CHAR_MINUS) begin
         kind = KIND_MINUS;
      end else begin
         kind = KIND_OTHER;
      end
      return kind;
   endfunction

endpackage

[src/ddlp_ifs.sv]
// request and response channel interfaces of the decimal list parser
interface ddlp_req_if;
   import ddlp_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface ddlp_rsp_if;
   import ddlp_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] field_0;
   logic signed [DATA_W-1:0] field_1;
   logic signed [DATA_W-1:0] field_2;
   logic signed [DATA_W-1:0] field_3;
   logic signed [DATA_W-1:0] field_4;
   logic signed [DATA_W-1:0] field_5;
   logic [OUT_FIELDS-1:0]    present_mask;

   modport source (output valid, output field_0, output field_1, output field_2,
                   output field_3, output field_4, output field_5,
                   output present_mask, input ready);
   modport sink (input valid, input field_0, input field_1, input field_2,
                 input field_3, input field_4, input field_5,
                 input present_mask, output ready);
endinterface

[src/ddlp_csr.sv]
// apb register file holding the absent field code
module ddlp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ddlp_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [ddlp_pkg::DATA_W-1:0]      pwdata,
   output logic [ddlp_pkg::DATA_W-1:0]      prdata,
   output logic                             pready,
   output logic [ddlp_pkg::DATA_W-1:0]      absent_value
);
   import ddlp_pkg::*;

   logic [DATA_W-1:0] absent_ff;
   logic [DATA_W-1:0] absent_in;
   logic              hit_absent;
   logic              wr_en;

   // paddr is shifted to drop the byte offset; no word address bits remain, so every address selects the register
   assign hit_absent = ((paddr >> 2) == REG_ABSENT_VALUE);
   assign pready     = 1'b1;
   assign wr_en      = psel && penable && pwrite && pready;

   always_comb begin
      absent_in = absent_ff;
      if (wr_en && hit_absent) begin
         absent_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         absent_ff <= ABSENT_RESET;
      end else begin
         absent_ff <= absent_in;
      end
   end

   assign prdata       = hit_absent ? absent_ff : '0;
   assign absent_value = absent_ff;

endmodule

[src/ddlp_parse_core.sv]
// per-character parse state, field lanes and result formation
`include "delimited_decimal_list_parser_macros.svh"

module ddlp_parse_core #(
   parameter int NUM_FIELDS = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  logic [ddlp_pkg::CHAR_W-1:0]  char_code,
   input  logic                         last_char,
   input  logic [ddlp_pkg::DATA_W-1:0]  absent_value,
   output ddlp_pkg::result_type         result
);
   import ddlp_pkg::*;

   localparam int IDX_W = $clog2(NUM_FIELDS + 1);

   logic [NUM_FIELDS-1:0][DATA_W-1:0] acc_ff, acc_in, acc_upd;
   logic [NUM_FIELDS-1:0]             seen_ff, seen_in, seen_upd;
   logic [NUM_FIELDS-1:0]             mask_ff, mask_in, mask_upd;
   logic [IDX_W-1:0]                  idx_ff, idx_in, idx_upd;
   logic                              neg_ff, neg_in, neg_upd;

   char_kind_type kind;
   logic          fields_open;
   logic [3:0]    digit;

   logic [OUT_FIELDS-1:0][DATA_W-1:0] fields_out;
   logic [OUT_FIELDS-1:0]             mask_out;

   assign kind        = classify(char_code);
   assign fields_open = (idx_ff < IDX_W'(NUM_FIELDS));
   assign digit       = 4'(char_code - CHAR_ZERO);

   always_comb begin
      idx_upd = idx_ff;
      neg_upd = neg_ff;
      if (fields_open) begin
         case (kind)
            KIND_SEP: begin
               idx_upd = idx_ff + 1'b1;
               neg_upd = 1'b0;
            end
            KIND_MINUS: begin
               neg_upd = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // one lane per field, only the lane at the current index moves
   for (genvar k = 0; k < NUM_FIELDS; k++) begin : g_lane
      logic              hit;
      logic [DATA_W-1:0] lane_acc;
      logic              lane_seen;
      logic              lane_mask;

      assign hit = (idx_ff == IDX_W'(k));

      always_comb begin
         lane_acc  = acc_ff[k];
         lane_seen = seen_ff[k];
         lane_mask = mask_ff[k];
         if (hit) begin
            case (kind)
               KIND_DIGIT: begin
                  lane_acc  = (acc_ff[k] << 3) + (acc_ff[k] << 1) + DATA_W'(digit);
                  lane_seen = 1'b1;
               end
               KIND_SEP: begin
                  if (neg_ff) begin
                     lane_acc = '0 - acc_ff[k];
                  end
                  lane_mask = seen_ff[k];
               end
               default: begin
               end
            endcase
         end
      end

      assign acc_upd[k]  = lane_acc;
      assign seen_upd[k] = lane_seen;
      assign mask_upd[k] = lane_mask;
   end

   // the last character of a string leaves the state cleared
   always_comb begin
      if (last_char) begin
         acc_in  = '0;
         seen_in = '0;
         mask_in = '0;
         idx_in  = '0;
         neg_in  = 1'b0;
      end else begin
         acc_in  = acc_upd;
         seen_in = seen_upd;
         mask_in = mask_upd;
         idx_in  = idx_upd;
         neg_in  = neg_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         seen_ff <= '0;
         mask_ff <= '0;
         idx_ff  <= '0;
         neg_ff  <= 1'b0;
      end else if (take) begin
         acc_ff  <= acc_in;
         seen_ff <= seen_in;
         mask_ff <= mask_in;
         idx_ff  <= idx_in;
         neg_ff  <= neg_in;
      end
   end

   for (genvar k = 0; k < OUT_FIELDS; k++) begin : g_out
      if (k < NUM_FIELDS) begin : g_live
         assign fields_out[k] = seen_upd[k] ? acc_upd[k] : absent_value;
         assign mask_out[k]   = mask_upd[k];
      end else begin : g_unused
         assign fields_out[k] = absent_value;
         assign mask_out[k]   = 1'b0;
      end
   end

   assign result.fields       = fields_out;
   assign result.present_mask = mask_out;

   `DDLP_ASSERT_IMPL(a_index_bound, 1'b1, idx_ff <= IDX_W'(NUM_FIELDS))
   `DDLP_ASSERT_NEXT(a_clear_after_last, take && last_char, idx_ff == '0 && seen_ff == '0 && !neg_ff)
   `DDLP_ASSERT_IMPL(a_mask_needs_digits, 1'b1, (mask_ff & ~seen_ff) == '0)

endmodule

[src/ddlp_out_reg.sv]
// result register between the parse logic and the response channel
module ddlp_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  ddlp_pkg::result_type  result,
   output logic                  can_load,
   ddlp_rsp_if.source            rsp_chan
);
   import ddlp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type payload_ff;

   assign can_load = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && can_load) begin
         payload_ff <= result;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.field_0      = $signed(payload_ff.fields[0]);
   assign rsp_chan.field_1      = $signed(payload_ff.fields[1]);
   assign rsp_chan.field_2      = $signed(payload_ff.fields[2]);
   assign rsp_chan.field_3      = $signed(payload_ff.fields[3]);
   assign rsp_chan.field_4      = $signed(payload_ff.fields[4]);
   assign rsp_chan.field_5      = $signed(payload_ff.fields[5]);
   assign rsp_chan.present_mask = payload_ff.present_mask;

endmodule

[src/delimited_decimal_list_parser.sv]
// delimited decimal list parser: request channel of characters in, one response per string
//
// requests carry one character each plus a flag marking the end of the string. up to
// NUM_FIELDS signed decimal integers separated by ';' or ':' are parsed; '-' negates a
// field when its separator arrives, other characters are ignored.
// a request is taken in every cycle while the result register is free or being read,
// so the sustained rate is one character per cycle; the parse lanes are the only
// logic between the state registers and the result register.
// the request flagged last produces one response, visible in the cycle after it is taken;
// the parse state clears in that same cycle so the next string can follow at once.
// when the receiver stalls with a response pending, req ready drops until it is taken.
// fields without digits report the absent code written at apb offset 0.
// reset clears the parse state and the pending response and loads the absent code
// with 32'h7fffffff; no clearing pass is needed.
module delimited_decimal_list_parser #(
   parameter int NUM_FIELDS = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   ddlp_req_if.sink                         req_chan,
   ddlp_rsp_if.source                       rsp_chan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ddlp_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [ddlp_pkg::DATA_W-1:0]      pwdata,
   output logic [ddlp_pkg::DATA_W-1:0]      prdata,
   output logic                             pready
);
   import ddlp_pkg::*;

   logic [DATA_W-1:0] absent_value;
   logic              take;
   logic              can_load;
   result_type        result;

   assign req_chan.ready = can_load;
   assign take           = req_chan.valid && req_chan.ready;

   ddlp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .absent_value (absent_value)
   );

   ddlp_parse_core #(
      .NUM_FIELDS (NUM_FIELDS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .char_code    (req_chan.char_code),
      .last_char    (req_chan.last_char),
      .absent_value (absent_value),
      .result       (result)
   );

   ddlp_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (take && req_chan.last_char),
      .result   (result),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

endmodule
